// ===== hdl/assert_macros.svh =====
// Assertion macros used by the filter back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("assertion failed");

`endif

// ===== hdl/supf_pkg.sv =====
// Shared constants of the stream pattern filter
package supf_pkg;

  localparam int BYTE_W = 8;
  localparam int PAT_W  = 64;
  localparam int LEN_W  = 4;
  localparam int IDX_W  = 1;

  localparam logic [IDX_W-1:0] REG_PATTERN_BYTES  = 1'd0;
  localparam logic [IDX_W-1:0] REG_PATTERN_LENGTH = 1'd1;

  localparam logic [PAT_W-1:0] PATTERN_BYTES_RESET  = '0;
  localparam logic [LEN_W-1:0] PATTERN_LENGTH_RESET = 4'd1;

endpackage

// ===== hdl/supf_if.sv =====
// Stream channel interfaces of the pattern filter
interface supf_in_if;
  logic                      valid;
  logic                      ready;
  logic [supf_pkg::BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface supf_out_if;
  logic                      valid;
  logic                      ready;
  logic [supf_pkg::BYTE_W-1:0] out_byte;
  logic                      found;
  logic                      last;

  modport source (output valid, output out_byte, output found, output last, input ready);
  modport sink   (input valid, input out_byte, input found, input last, output ready);
endinterface

// ===== hdl/supf_front.sv =====
// Front end: accepts bytes, matches against the pattern, queues emission jobs
module supf_front #(
  parameter int MAX_PATTERN = 8,
  localparam int CNT_W = $clog2(MAX_PATTERN + 1),
  localparam int JOB_W = supf_pkg::BYTE_W * MAX_PATTERN + CNT_W + 1
) (
  input  logic                        clk,
  input  logic                        rst,
  supf_in_if.sink                     in_ch,
  input  logic                        cfg_wr_en,
  input  logic [supf_pkg::IDX_W-1:0]  cfg_index,
  input  logic [supf_pkg::PAT_W-1:0]  cfg_data,
  input  logic                        queue_full,
  output logic                        push,
  output logic [JOB_W-1:0]            push_data
);

  logic [supf_pkg::PAT_W-1:0]  pattern_bytes;
  logic [supf_pkg::LEN_W-1:0]  pattern_length;
  logic [supf_pkg::BYTE_W-1:0] held [MAX_PATTERN];
  logic [CNT_W-1:0]            held_count;
  logic                        stopped;

  logic [CNT_W-1:0]            plen;
  logic [CNT_W-1:0]            n;
  logic [supf_pkg::BYTE_W-1:0] seq [MAX_PATTERN];
  logic [supf_pkg::BYTE_W-1:0] held_next [MAX_PATTERN];
  logic [CNT_W-1:0]            start;
  logic                        any_match;
  logic                        full;
  logic                        accept;
  logic [supf_pkg::BYTE_W*MAX_PATTERN-1:0] job_bytes;

  always_comb begin
    if (pattern_length == '0) begin
      plen = CNT_W'(1);
    end else if (int'(pattern_length) > MAX_PATTERN) begin
      plen = CNT_W'(MAX_PATTERN);
    end else begin
      plen = CNT_W'(pattern_length);
    end
  end

  assign n = held_count + CNT_W'(1);

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      seq[j] = (CNT_W'(j) == held_count) ? in_ch.in_byte : held[j];
      job_bytes[supf_pkg::BYTE_W*j +: supf_pkg::BYTE_W] = seq[j];
    end
  end

  always_comb begin
    logic ok;
    ok        = 1'b0;
    any_match = 1'b0;
    start     = n;
    for (int s = MAX_PATTERN - 1; s >= 0; s--) begin
      ok = (s < int'(n)) && ((int'(n) - s) <= int'(plen));
      for (int i = 0; i < MAX_PATTERN - s; i++) begin
        if ((i < int'(n) - s) &&
            (seq[s+i] != pattern_bytes[supf_pkg::BYTE_W*i +: supf_pkg::BYTE_W])) begin
          ok = 1'b0;
        end
      end
      if (ok) begin
        any_match = 1'b1;
        start     = CNT_W'(s);
      end
    end
  end

  assign full = any_match && ((n - start) == plen);

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      held_next[j] = seq[j];
      for (int k = 0; k < MAX_PATTERN - j; k++) begin
        if (CNT_W'(k) == start) begin
          held_next[j] = seq[k+j];
        end
      end
    end
  end

  assign in_ch.ready = stopped || !queue_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && !stopped && (full || start != '0);
  assign push_data   = {full, start, job_bytes};

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= supf_pkg::PATTERN_BYTES_RESET;
      pattern_length <= supf_pkg::PATTERN_LENGTH_RESET;
      held_count     <= '0;
      stopped        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          supf_pkg::REG_PATTERN_BYTES:  pattern_bytes  <= cfg_data;
          supf_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[supf_pkg::LEN_W-1:0];
          default: begin
          end
        endcase
      end
      if (accept && !stopped) begin
        if (full) begin
          stopped    <= 1'b1;
          held_count <= '0;
        end else begin
          held_count <= n - start;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !stopped && !full) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        held[j] <= held_next[j];
      end
    end
  end

endmodule

// ===== hdl/supf_queue.sv =====
// Short job queue between the front and back ends
module supf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             valid,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hdl/supf_back.sv =====
// Back end: drains jobs, one transaction per cycle but for stalls and job loads
`include "assert_macros.svh"

module supf_back #(
  parameter int MAX_PATTERN = 8,
  localparam int CNT_W = $clog2(MAX_PATTERN + 1),
  localparam int JOB_W = supf_pkg::BYTE_W * MAX_PATTERN + CNT_W + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  logic [JOB_W-1:0] q_data,
  output logic             q_pop,
  supf_out_if.source       out_ch
);

  localparam int BYTES_W = supf_pkg::BYTE_W * MAX_PATTERN;

  logic                        job_valid;
  logic [BYTES_W-1:0]          job_bytes;
  logic [CNT_W-1:0]            job_count;
  logic                        job_full;
  logic [CNT_W-1:0]            job_idx;

  logic                        out_valid;
  logic [supf_pkg::BYTE_W-1:0] out_byte_r;
  logic                        out_found;
  logic                        out_last;

  logic                        adv;
  logic                        final_byte;

  assign adv        = !out_valid || out_ch.ready;
  assign q_pop      = !job_valid && q_valid;
  assign final_byte = !job_full && (job_idx == job_count - CNT_W'(1));

  assign out_ch.valid    = out_valid;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.found    = out_found;
  assign out_ch.last     = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (job_valid && adv) begin
        out_valid <= 1'b1;
        if (job_idx != job_count) begin
          out_byte_r <= job_bytes[supf_pkg::BYTE_W*job_idx +: supf_pkg::BYTE_W];
          out_found  <= 1'b0;
          out_last   <= final_byte;
          job_idx    <= job_idx + CNT_W'(1);
          if (final_byte) begin
            job_valid <= 1'b0;
          end
        end else begin
          out_byte_r <= '0;
          out_found  <= 1'b1;
          out_last   <= 1'b1;
          job_valid  <= 1'b0;
        end
      end else begin
        if (out_ch.ready) begin
          out_valid <= 1'b0;
        end
        if (q_pop) begin
          job_valid <= 1'b1;
          job_idx   <= '0;
          job_full  <= q_data[JOB_W-1];
          job_count <= q_data[BYTES_W +: CNT_W];
          job_bytes <= q_data[BYTES_W-1:0];
        end
      end
    end
  end

  `ASSERT_ALWAYS(a_idx_in_range, clk, rst, !job_valid || job_idx <= job_count)
  `ASSERT_IMPLY(a_found_is_last, clk, rst, out_valid && out_found, out_last && out_byte_r == '0)
  `ASSERT_IMPLY(a_no_empty_job, clk, rst, job_valid && !job_full, job_count != '0)
  `ASSERT_NEXT(a_pop_loads_job, clk, rst, q_pop, job_valid)

endmodule

// ===== hdl/stream_until_pattern_filter_top.sv =====
// Top level of the stream pattern filter
// Bytes pass through until the configured pattern first appears; the pattern and
// everything after it are dropped and one found transaction is given instead.
// The front end takes one input byte per clock while its two-entry job queue has
// room, and after the match it takes and drops every byte. The back end loads one
// job at a time and emits its results in order, taking the next job only after
// the last one is drained (a byte that releases no results queues no job and costs
// nothing there); sustained throughput is set by that drain. Configuration writes
// are taken in any cycle; write them only while the block is idle.
module stream_until_pattern_filter_top #(
  parameter int MAX_PATTERN = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  supf_in_if.sink                    in_ch,
  supf_out_if.source                 out_ch,
  input  logic                       cfg_wr_en,
  input  logic [supf_pkg::IDX_W-1:0] cfg_index,
  input  logic [supf_pkg::PAT_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int JOB_W = supf_pkg::BYTE_W * MAX_PATTERN + CNT_W + 1;

  logic             push;
  logic [JOB_W-1:0] push_data;
  logic             queue_full;
  logic             q_valid;
  logic             q_pop;
  logic [JOB_W-1:0] q_data;

  supf_front #(.MAX_PATTERN(MAX_PATTERN)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  supf_queue #(.WIDTH(JOB_W), .DEPTH(2)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .full      (queue_full),
    .valid     (q_valid),
    .rd_data   (q_data)
  );

  supf_back #(.MAX_PATTERN(MAX_PATTERN)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== bench/stream_until_pattern_filter_top_tb.sv =====
// Self-checking testbench for the stream pattern filter: directed table, random phases, match at end
`timescale 1ns / 100ps

module stream_until_pattern_filter_top_tb;

  localparam int MAX_PATTERN = 8;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES = 6;
  localparam int PHASE_BYTES = 55;

  typedef struct packed {
    logic [supf_pkg::BYTE_W-1:0] out_byte;
    logic                        found;
    logic                        last;
  } emit_t;

  typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [supf_pkg::IDX_W-1:0] index;
    logic [supf_pkg::PAT_W-1:0] data;
    logic                       typed;
    emit_t                      want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                       cfg_wr_en;
  logic [supf_pkg::IDX_W-1:0] cfg_index;
  logic [supf_pkg::PAT_W-1:0] cfg_data;

  supf_in_if  in_ch ();
  supf_out_if out_ch ();

  stream_until_pattern_filter_top #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // predictor state
  logic [supf_pkg::PAT_W-1:0]  pat_reg = supf_pkg::PATTERN_BYTES_RESET;
  logic [supf_pkg::LEN_W-1:0]  len_reg = supf_pkg::PATTERN_LENGTH_RESET;
  logic [supf_pkg::BYTE_W-1:0] held_q [MAX_PATTERN];
  int                          held_n = 0;
  bit                          halted = 1'b0;

  emit_t awaited [$];
  int    mismatches = 0;
  int    emits_seen = 0;
  int    bytes_sent = 0;
  int    settings_used = 0;
  int    cycle_cnt = 0;
  int    stall_left = 0;
  int    gap_odds = 3;
  bit    calm = 1'b0;

  row_t plan [25] = '{
    '{ROW_BYTE,  supf_pkg::REG_PATTERN_BYTES,  64'hFF, 1'b1, '{8'hFF, 1'b0, 1'b1}},
    '{ROW_BYTE,  supf_pkg::REG_PATTERN_BYTES,  64'h80, 1'b1, '{8'h80, 1'b0, 1'b1}},
    '{ROW_WRITE, supf_pkg::REG_PATTERN_LENGTH, 64'd0,  1'b0, '0},
    '{ROW_WRITE, supf_pkg::REG_PATTERN_BYTES,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
    '{ROW_BYTE,  supf_pkg::REG_PATTERN_BYTES,  64'h00, 1'b1, '{8'h00, 1'b0, 1'b1}},
    '{ROW_WRITE, supf_pkg::REG_PATTERN_LENGTH, 64'd15, 1'b0, '0},
    '{ROW_BYTE,  supf_pkg::REG_PATTERN_BYTES,  64'hFF, 1'b0, '0},
    '{ROW_BYTE,  supf_pkg::REG_PATTERN_BYTES,  64'hFF, 1'b0, '0},
    '{ROW_BYTE,  supf_pkg::REG_PATTERN_BYTES,  64'hFF, 1'b0, '0},
    '{ROW_BYTE,  supf_pkg::REG_PATTERN_BYTES,  64'hFF, 1'b0, '0},
    '{ROW_BYTE,  supf_pkg::REG_PATTERN_BYTES,  64'hFF, 1'b0, '0},
    '{ROW_BYTE,  supf_pkg::REG_PATTERN_BYTES,  64'hFF, 1'b0, '0},
    '{ROW_BYTE,  supf_pkg::REG_PATTERN_BYTES,  64'hFF, 1'b0, '0},
    '{ROW_BYTE,  supf_pkg::REG_PATTERN_BYTES,  64'h7F, 1'b0, '0},
    '{ROW_WRITE, supf_pkg::REG_PATTERN_BYTES,  64'h4341_4241_4241_4241, 1'b0, '0},
    '{ROW_BYTE,  supf_pkg::REG_PATTERN_BYTES,  64'h41, 1'b0, '0},
    '{ROW_BYTE,  supf_pkg::REG_PATTERN_BYTES,  64'h42, 1'b0, '0},
    '{ROW_BYTE,  supf_pkg::REG_PATTERN_BYTES,  64'h41, 1'b0, '0},
    '{ROW_BYTE,  supf_pkg::REG_PATTERN_BYTES,  64'h42, 1'b0, '0},
    '{ROW_BYTE,  supf_pkg::REG_PATTERN_BYTES,  64'h41, 1'b0, '0},
    '{ROW_BYTE,  supf_pkg::REG_PATTERN_BYTES,  64'h42, 1'b0, '0},
    '{ROW_BYTE,  supf_pkg::REG_PATTERN_BYTES,  64'h41, 1'b0, '0},
    '{ROW_BYTE,  supf_pkg::REG_PATTERN_BYTES,  64'h42, 1'b0, '0},
    '{ROW_WRITE, supf_pkg::REG_PATTERN_LENGTH, 64'd3,  1'b0, '0},
    '{ROW_BYTE,  supf_pkg::REG_PATTERN_BYTES,  64'h44, 1'b0, '0}
  };

  function automatic int match_len();
    if (len_reg == 0) return 1;
    if (len_reg > MAX_PATTERN) return MAX_PATTERN;
    return int'(len_reg);
  endfunction

  function automatic bit completes_pattern(input logic [supf_pkg::BYTE_W-1:0] b);
    logic [supf_pkg::BYTE_W-1:0] seq [MAX_PATTERN];
    int n, pl, i;
    if (halted) return 1'b0;
    for (i = 0; i < held_n; i++) seq[i] = held_q[i];
    seq[held_n] = b;
    n = held_n + 1;
    pl = match_len();
    if (n < pl) return 1'b0;
    for (i = 0; i < pl; i++)
      if (seq[n - pl + i] != pat_reg[8*i +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void filter_byte(input logic [supf_pkg::BYTE_W-1:0] b,
                                      ref emit_t res [$]);
    logic [supf_pkg::BYTE_W-1:0] seq [MAX_PATTERN];
    int n, pl, s, i, start;
    bit hit, full, ok;
    res.delete();
    if (halted) return;
    pl = match_len();
    for (i = 0; i < held_n; i++) seq[i] = held_q[i];
    seq[held_n] = b;
    n = held_n + 1;
    hit = 1'b0;
    full = 1'b0;
    start = n;
    for (s = 0; s < n && !hit; s++) begin
      if (n - s <= pl) begin
        ok = 1'b1;
        for (i = 0; i < n - s; i++)
          if (seq[s + i] != pat_reg[8*i +: 8]) ok = 1'b0;
        if (ok) begin
          hit = 1'b1;
          start = s;
          full = (n - s == pl);
        end
      end
    end
    for (i = 0; i < start; i++)
      res.push_back(emit_t'{seq[i], 1'b0, (!full && i == start - 1)});
    if (full) begin
      res.push_back(emit_t'{8'h00, 1'b1, 1'b1});
      halted = 1'b1;
      held_n = 0;
      return;
    end
    held_n = n - start;
    for (i = 0; i < held_n; i++) held_q[i] = seq[start + i];
  endfunction

  task automatic send_byte(input logic [supf_pkg::BYTE_W-1:0] b, input bit typed,
                           input emit_t want);
    emit_t fresh [$];
    int gap;
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    filter_byte(b, fresh);
    if (typed) awaited.push_back(want);
    else foreach (fresh[j]) awaited.push_back(fresh[j]);
    bytes_sent++;
  endtask

  // replace any byte that would end the stream early
  task automatic feed_byte(input logic [supf_pkg::BYTE_W-1:0] b);
    while (completes_pattern(b)) b = 8'($urandom);
    send_byte(b, 1'b0, '0);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [supf_pkg::IDX_W-1:0] idx,
                           input logic [supf_pkg::PAT_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == supf_pkg::REG_PATTERN_BYTES) pat_reg = val;
    else len_reg = val[supf_pkg::LEN_W-1:0];
    if (idx == supf_pkg::REG_PATTERN_LENGTH) settings_used++;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    emit_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (awaited.size() == 0) begin
        $error("unexpected transaction: out_byte %h found %b last %b",
               out_ch.out_byte, out_ch.found, out_ch.last);
        mismatches++;
      end else begin
        want = awaited.pop_front();
        emits_seen++;
        if (out_ch.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, out_ch.out_byte);
          mismatches++;
        end
        if (out_ch.found !== want.found) begin
          $error("found: expected %b, got %b", want.found, out_ch.found);
          mismatches++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_ch.last);
          mismatches++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("stream_until_pattern_filter_top verification failed");
      $finish;
    end
  end

  initial begin
    logic [supf_pkg::PAT_W-1:0] pat;
    logic [supf_pkg::LEN_W-1:0] len;
    int mode, r, k, i, phase_start;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= '0;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= supf_pkg::REG_PATTERN_BYTES;
    cfg_data      <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[n]) begin
      if (plan[n].kind == ROW_WRITE) begin
        settle();
        write_reg(plan[n].index, plan[n].data);
      end else begin
        send_byte(plan[n].data[supf_pkg::BYTE_W-1:0], plan[n].typed, plan[n].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      mode = $urandom_range(0, 4);
      case (mode)
        0: pat = '0;
        1: pat = '1;
        2: pat = {$urandom, $urandom};
        default: begin
          for (i = 0; i < MAX_PATTERN; i++) pat[8*i +: 8] = 8'h41 + 8'($urandom_range(0, 1));
        end
      endcase
      r = $urandom_range(0, 19);
      if (r < 16) len = supf_pkg::LEN_W'((r % MAX_PATTERN) + 1);
      else if (r == 16) len = '0;
      else len = supf_pkg::LEN_W'($urandom_range(9, 15));
      write_reg(supf_pkg::REG_PATTERN_BYTES, pat);
      write_reg(supf_pkg::REG_PATTERN_LENGTH, supf_pkg::PAT_W'(len));
      calm = (ph == PHASES - 1);
      gap_odds = (ph % 3 == 1) ? 0 : $urandom_range(2, 4);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        if ($urandom_range(0, 3) != 0) begin
          k = $urandom_range(1, match_len());
          for (i = 0; i < k; i++) feed_byte(pat_reg[8*i +: 8]);
          if ($urandom_range(0, 1) == 1) feed_byte(8'($urandom));
        end else begin
          feed_byte(8'($urandom));
        end
      end
    end

    // hold a partial match, shorten the pattern, then complete it at a later start
    settle();
    write_reg(supf_pkg::REG_PATTERN_BYTES, 64'h4544_4342_4143_4241);
    write_reg(supf_pkg::REG_PATTERN_LENGTH, supf_pkg::PAT_W'(8));
    send_byte(8'h5A, 1'b0, '0);
    send_byte(8'h41, 1'b0, '0);
    send_byte(8'h42, 1'b0, '0);
    send_byte(8'h43, 1'b0, '0);
    send_byte(8'h41, 1'b0, '0);
    send_byte(8'h42, 1'b0, '0);
    settle();
    write_reg(supf_pkg::REG_PATTERN_LENGTH, supf_pkg::PAT_W'(3));
    send_byte(8'h43, 1'b0, '0);
    repeat (3) send_byte(8'($urandom), 1'b0, '0);
    settle();
    write_reg(supf_pkg::REG_PATTERN_BYTES, {$urandom, $urandom});
    send_byte(8'($urandom), 1'b0, '0);

    in_ch.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d input bytes and %0d checked transactions over %0d lengths,",
             bytes_sent, emits_seen, settings_used);
    $display("including length clamping, mid-stream changes and a final match.");
    if (mismatches == 0) begin
      $display("stream_until_pattern_filter_top verification clean");
    end else begin
      $display("stream_until_pattern_filter_top verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/supf_pkg.sv
hdl/supf_if.sv
hdl/supf_front.sv
hdl/supf_queue.sv
hdl/supf_back.sv
hdl/stream_until_pattern_filter_top.sv
bench/stream_until_pattern_filter_top_tb.sv
